FILE: rtl/sbglue_pkg.sv
package sbglue_pkg;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] address;
		logic [7:0]  data;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        from_rom;
		logic [19:0] rom_offset;
		logic        chip_access;
		logic [1:0]  chip_port;
		logic        chip_write;
		logic        nmi_pending_out;
		logic        nmi_enabled_out;
		logic [7:0]  reply_value;
		logic [7:0]  command_value;
	} rsp_t;

	typedef struct packed {
		logic        start;
		logic [20:0] dividend;
		logic [20:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic        done;
		logic [19:0] rem;
	} mod_rsp_t;

	localparam logic [2:0] CMD_MEM_RD  = 3'd0;
	localparam logic [2:0] CMD_MEM_WR  = 3'd1;
	localparam logic [2:0] CMD_PORT_RD = 3'd2;
	localparam logic [2:0] CMD_PORT_WR = 3'd3;
	localparam logic [2:0] CMD_HOST_WR = 3'd4;

	localparam logic [3:0] NIB_LATCH  = 4'h0;
	localparam logic [3:0] NIB_BANK_D = 4'h8;
	localparam logic [3:0] NIB_BANK_C = 4'h9;
	localparam logic [3:0] NIB_BANK_B = 4'hA;
	localparam logic [3:0] NIB_BANK_A = 4'hB;
	localparam logic [3:0] NIB_REPLY  = 4'hC;
	localparam logic [4:0] PORT_NMI_OFF = 5'h18;
	localparam logic [2:0] PORT_NMI_ON_HI = 3'b010;

	localparam logic [15:0] RAM_START     = 16'hF800;
	localparam logic [20:0] ROM_BANK_BASE = 21'h10000;
	localparam logic [20:0] ROM_128K      = 21'h20000;
	localparam logic [20:0] ROM_128K_EFF  = 21'h30000;
	localparam logic [20:0] ROM_MAX       = 21'h100000;
	localparam logic [16:0] ROM_128K_MASK = 17'h1FFFF;

	localparam logic [7:0] BANK_A_RST = 8'h02;
	localparam logic [7:0] BANK_B_RST = 8'h06;
	localparam logic [7:0] BANK_C_RST = 8'h0E;
	localparam logic [7:0] BANK_D_RST = 8'h1E;
	localparam logic [7:0] REPLY_RST  = 8'hFF;
	localparam logic [7:0] BYTE_FF    = 8'hFF;

endpackage

FILE: rtl/sound_cpu_bus_bank_and_latch_glue.sv
// Bus glue of a sound CPU: bank windows, work RAM and host command/reply latches.
// req carries one bus access per beat (req_valid/req_stall); rsp returns one
// beat per access (rsp_valid/rsp_stall). cfg_valid/cfg_ready writes rom_size;
// cfg_ready is always high, and the user must see that writes are made only
// while the block is idle; the block itself does not enforce it.
// An access passes an execute state, then a finish state raising rsp_valid;
// port and host accesses, memory writes and constant reads need no more. Work
// RAM reads add a wait state for the registered RAM array read. ROM reads add
// a wrap state, after a bank-base state for a bank window; wrapping the base
// or ROM address uses a shared remainder unit at one quotient bit per cycle.
// One access is in flight at a time; req_stall is high while it is worked on,
// so the next access is accepted in the cycle after rsp_valid rises at the earliest.
// A finished beat is held in the output register while rsp_stall is high; the
// next access may be accepted then, and waits before its result is placed.
// After reset the work RAM is cleared one byte per cycle, all RAM_BYTES bytes,
// with req_stall high throughout; the bank registers, latches and flags take
// their reset values at once.
module sound_cpu_bus_bank_and_latch_glue #(
	parameter int RAM_BYTES = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  sbglue_pkg::req_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output sbglue_pkg::rsp_t rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [20:0]      cfg_data
);
	import sbglue_pkg::*;

	localparam int AW = $clog2(RAM_BYTES);
	localparam int OFS = 'hF800 % RAM_BYTES;
	localparam logic [11:0] RAM_N = 12'(RAM_BYTES);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_BASE,
		ST_BMOD,
		ST_WRAP,
		ST_WMOD,
		ST_FINISH
	} state_t;

	state_t      state_q;
	req_t        req_s1;
	rsp_t        res_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;
	logic [20:0] rom_size_q;
	logic [AW-1:0] clr_q;
	logic [7:0]  bank_a_q, bank_b_q, bank_c_q, bank_d_q;
	logic [7:0]  cmd_latch_q, reply_q;
	logic        nmi_en_q, nmi_pend_q;
	logic [17:0] mbits_q;
	logic [13:0] woff_q;
	logic [20:0] a_q;

	logic [7:0]  ram [RAM_BYTES];
	logic [7:0]  ram_rd_q;
	logic        ram_we;
	logic [AW-1:0] ram_wa;
	logic [7:0]  ram_wd;
	logic [AW-1:0] ram_idx;
	logic [11:0] idx_v;

	logic [20:0] eff;
	logic [20:0] span;
	logic [17:0] mask;
	logic        is128;
	logic        ram_hit;
	logic [3:0]  nib;
	logic [4:0]  low5;
	logic [7:0]  hi;
	logic [17:0] win_bits;
	logic [13:0] win_off;
	logic [20:0] base;
	logic        base_lt;
	logic        out_free;

	mod_req_t mod_req;
	mod_rsp_t mod_rsp;

	function automatic logic [19:0] phys(input logic [20:0] x, input logic big128);
		logic [20:0] y;
		y = x - ROM_BANK_BASE;
		if (big128 && x >= ROM_BANK_BASE) begin
			phys = {3'b000, y[16:0] & ROM_128K_MASK};
		end else begin
			phys = x[19:0];
		end
	endfunction

	sbglue_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	assign is128   = (rom_size_q == ROM_128K);
	assign eff     = is128 ? ROM_128K_EFF : rom_size_q;
	assign span    = eff - ROM_BANK_BASE;
	assign mask    = 18'(eff - ROM_BANK_BASE - 21'd1);
	assign ram_hit = (req_s1.address >= RAM_START);
	assign nib     = req_s1.address[3:0];
	assign low5    = req_s1.address[4:0];
	assign hi      = req_s1.address[15:8];
	assign base    = ROM_BANK_BASE + {3'b000, mbits_q};
	assign base_lt = (base < eff);
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		idx_v = {1'b0, req_s1.address[10:0]} + 12'(OFS);
		for (int i = 0; i < 8; i++) begin
			if (idx_v >= RAM_N) begin
				idx_v = idx_v - RAM_N;
			end
		end
		ram_idx = idx_v[AW-1:0];
	end

	always_comb begin
		priority if (!req_s1.address[14]) begin
			win_bits = {bank_a_q[3:0], 14'b0};
			win_off  = req_s1.address[13:0];
		end else if (!req_s1.address[13]) begin
			win_bits = {bank_b_q[4:0], 13'b0};
			win_off  = {1'b0, req_s1.address[12:0]};
		end else if (!req_s1.address[12]) begin
			win_bits = {bank_c_q[5:0], 12'b0};
			win_off  = {2'b00, req_s1.address[11:0]};
		end else begin
			win_bits = {bank_d_q[6:0], 11'b0};
			win_off  = {3'b000, req_s1.address[10:0]};
		end
	end

	always_comb begin
		mod_req.start    = 1'b0;
		mod_req.dividend = a_q;
		mod_req.divisor  = eff;
		if (state_q == ST_BASE) begin
			mod_req.start    = !base_lt;
			mod_req.dividend = {3'b000, mbits_q};
			mod_req.divisor  = span;
		end else if (state_q == ST_WRAP) begin
			mod_req.start = (a_q >= eff);
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = ram_idx;
		ram_wd = req_s1.data;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_wa = clr_q;
			ram_wd = '0;
		end else if (state_q == ST_EXEC && req_s1.command == CMD_MEM_WR && ram_hit) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram[ram_wa] <= ram_wd;
		end
		ram_rd_q <= ram[ram_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			req_s1      <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			rom_size_q  <= '0;
			clr_q       <= '0;
			bank_a_q    <= BANK_A_RST;
			bank_b_q    <= BANK_B_RST;
			bank_c_q    <= BANK_C_RST;
			bank_d_q    <= BANK_D_RST;
			cmd_latch_q <= '0;
			reply_q     <= REPLY_RST;
			nmi_en_q    <= 1'b0;
			nmi_pend_q  <= 1'b0;
			mbits_q     <= '0;
			woff_q      <= '0;
			a_q         <= '0;
		end else begin
			if (cfg_valid) begin
				rom_size_q <= (cfg_data > ROM_MAX) ? ROM_MAX : cfg_data;
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(RAM_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						req_s1  <= req;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_q   <= '0;
					state_q <= ST_FINISH;
					unique case (req_s1.command)
						CMD_MEM_RD: begin
							if (ram_hit) begin
								state_q <= ST_RDWAIT;
							end else if (rom_size_q == '0) begin
								res_q.read_data <= BYTE_FF;
							end else if (!req_s1.address[15]) begin
								a_q     <= {5'b0, req_s1.address};
								state_q <= ST_WRAP;
							end else if (eff <= ROM_BANK_BASE) begin
								a_q     <= {7'b0, win_off};
								state_q <= ST_WRAP;
							end else begin
								mbits_q <= win_bits & mask;
								woff_q  <= win_off;
								state_q <= ST_BASE;
							end
						end
						CMD_MEM_WR: begin
						end
						CMD_PORT_RD: begin
							if (nib == NIB_LATCH) begin
								nmi_pend_q      <= 1'b0;
								res_q.read_data <= cmd_latch_q;
							end else if (nib[3:2] == 2'b01) begin
								res_q.chip_access <= 1'b1;
								res_q.chip_port   <= nib[1:0];
							end else if (nib == NIB_BANK_D) begin
								bank_d_q <= hi;
							end else if (nib == NIB_BANK_C) begin
								bank_c_q <= hi;
							end else if (nib == NIB_BANK_B) begin
								bank_b_q <= hi;
							end else if (nib == NIB_BANK_A) begin
								bank_a_q <= hi;
							end else if (nib != NIB_REPLY) begin
								res_q.read_data <= BYTE_FF;
							end
						end
						CMD_PORT_WR: begin
							if (low5[4:2] == PORT_NMI_ON_HI) begin
								nmi_en_q <= 1'b1;
							end else if (low5 == PORT_NMI_OFF) begin
								nmi_en_q <= 1'b0;
							end else if (nib == NIB_LATCH) begin
								cmd_latch_q <= '0;
							end else if (nib[3:2] == 2'b01) begin
								res_q.chip_access <= 1'b1;
								res_q.chip_port   <= nib[1:0];
								res_q.chip_write  <= 1'b1;
							end else if (nib == NIB_REPLY) begin
								reply_q <= req_s1.data;
							end
						end
						CMD_HOST_WR: begin
							cmd_latch_q <= req_s1.data;
							nmi_pend_q  <= 1'b1;
						end
						default: begin
						end
					endcase
				end
				ST_RDWAIT: begin
					res_q.read_data <= ram_rd_q;
					state_q         <= ST_FINISH;
				end
				ST_BASE: begin
					if (base_lt) begin
						a_q     <= base + {7'b0, woff_q};
						state_q <= ST_WRAP;
					end else begin
						state_q <= ST_BMOD;
					end
				end
				ST_BMOD: begin
					if (mod_rsp.done) begin
						a_q     <= ROM_BANK_BASE + {1'b0, mod_rsp.rem} + {7'b0, woff_q};
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (a_q >= eff) begin
						state_q <= ST_WMOD;
					end else begin
						res_q.from_rom   <= 1'b1;
						res_q.rom_offset <= phys(a_q, is128);
						state_q          <= ST_FINISH;
					end
				end
				ST_WMOD: begin
					if (mod_rsp.done) begin
						res_q.from_rom   <= 1'b1;
						res_q.rom_offset <= phys({1'b0, mod_rsp.rem}, is128);
						state_q          <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						rsp_q                 <= res_q;
						rsp_q.nmi_pending_out <= nmi_pend_q;
						rsp_q.nmi_enabled_out <= nmi_en_q;
						rsp_q.reply_value     <= reply_q;
						rsp_q.command_value   <= cmd_latch_q;
						rsp_valid_q           <= 1'b1;
						state_q               <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/sbglue_mod.sv
module sbglue_mod (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbglue_pkg::mod_req_t req,
	output sbglue_pkg::mod_rsp_t rsp
);
	import sbglue_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t      state_q;
	logic [19:0] r_q;
	logic [20:0] x_q;
	logic [20:0] d_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [20:0] trial;

	assign trial = {r_q, x_q[20]};
	assign rsp.done = done_q;
	assign rsp.rem  = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			x_q     <= '0;
			d_q     <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						d_q <= req.divisor;
						if (req.dividend < req.divisor) begin
							r_q    <= req.dividend[19:0];
							done_q <= 1'b1;
						end else begin
							r_q     <= '0;
							x_q     <= req.dividend;
							cnt_q   <= 5'd21;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (trial >= d_q) begin
						r_q <= 20'(trial - d_q);
					end else begin
						r_q <= trial[19:0];
					end
					x_q   <= {x_q[19:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
